/* rtl/phcc_pkg.sv */
package phcc_pkg;

  // decision codes
  localparam logic [1:0] DEC_PASS = 2'd0;
  localparam logic [1:0] DEC_KEEP = 2'd1;
  localparam logic [1:0] DEC_DENY = 2'd2;

  // cache class that may carry the ambiguous mark
  localparam logic [1:0] CLASS_AMBIG = 2'd2;
  // cache class of an exact-sample keep
  localparam logic [1:0] CLASS_EXACT = 2'd0;

  // one probe hit of a read
  typedef struct packed {
    logic               hit_valid;
    logic [15:0]        hit_sample;
    logic [1:0]         hit_class;
    logic               hit_ambiguous;
    logic [14:0]        hit_gene;
    logic signed [7:0]  hit_offset;
    logic [15:0]        read_sample;
    logic               last_hit;
  } hit_t;

  // decision for one read
  typedef struct packed {
    logic [1:0]         decision;
    logic [14:0]        gene_index;
    logic [1:0]         class_out;
    logic               ambiguous_code;
    logic signed [7:0]  offset_out;
  } verdict_t;

endpackage

/* rtl/probe_hit_consensus_classifier_top.sv */
// channel   | signals                          | payload
// ----------+----------------------------------+-------------------
// probe     | probe_valid, probe_stall, probe  | phcc_pkg::hit_t
// verdict   | verdict_valid, verdict_stall,    | phcc_pkg::verdict_t
//           | verdict                          |
//
// One probe hit per cycle unless a held verdict stalls a last hit: a hit goes
// through an input register and is then folded into the per-read flags, and the
// decision of a read is loaded into the output register when its last hit passes.
// Synchronous reset clears the per-read flags and both valid bits.
// A stalled verdict only holds back a last hit; other hits keep flowing.
module probe_hit_consensus_classifier_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               probe_valid,
  output logic               probe_stall,
  input  phcc_pkg::hit_t     probe,
  output logic               verdict_valid,
  input  logic               verdict_stall,
  output phcc_pkg::verdict_t verdict
);

  // input register
  logic           in_v;
  phcc_pkg::hit_t in_r;

  // per-read state
  logic               exact_done, exact_done_next;
  logic [14:0]        exact_gene, exact_gene_next;
  logic signed [7:0]  exact_offset, exact_offset_next;
  logic               ambig_seen, ambig_seen_next;
  logic signed [7:0]  ambig_offset, ambig_offset_next;
  logic               mismatch_seen, mismatch_seen_next;
  logic signed [7:0]  mismatch_offset, mismatch_offset_next;
  logic               loose_seen, loose_seen_next;
  logic [14:0]        loose_gene, loose_gene_next;
  logic [15:0]        loose_sample, loose_sample_next;
  logic [1:0]         loose_class, loose_class_next;
  logic signed [7:0]  loose_offset, loose_offset_next;
  logic               conflict_seen, conflict_seen_next;
  logic signed [7:0]  conflict_offset, conflict_offset_next;

  logic               adv;
  logic               matched, mismatched;
  logic [15:0]        key;
  phcc_pkg::verdict_t verdict_next;

  // the registered hit moves on unless it ends a read while the verdict is held
  assign adv = in_v && (!in_r.last_hit || !verdict_valid || !verdict_stall);
  assign probe_stall = in_v && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (!probe_stall) begin
      in_v <= probe_valid;
    end
    if (!probe_stall) begin
      in_r <= probe;
    end
  end

  // sample comparisons of the registered hit
  assign matched    = (in_r.hit_sample != 16'd0) && (in_r.hit_sample == in_r.read_sample);
  assign mismatched = (in_r.hit_sample != 16'd0) && (in_r.hit_sample != in_r.read_sample);
  assign key        = matched ? in_r.read_sample : 16'd0;

  // fold the hit into the read state
  always_comb begin
    exact_done_next      = exact_done;
    exact_gene_next      = exact_gene;
    exact_offset_next    = exact_offset;
    ambig_seen_next      = ambig_seen;
    ambig_offset_next    = ambig_offset;
    mismatch_seen_next   = mismatch_seen;
    mismatch_offset_next = mismatch_offset;
    loose_seen_next      = loose_seen;
    loose_gene_next      = loose_gene;
    loose_sample_next    = loose_sample;
    loose_class_next     = loose_class;
    loose_offset_next    = loose_offset;
    conflict_seen_next   = conflict_seen;
    conflict_offset_next = conflict_offset;
    if (adv && in_r.hit_valid && !exact_done) begin
      if (in_r.hit_class == phcc_pkg::CLASS_AMBIG && in_r.hit_ambiguous) begin
        ambig_seen_next   = 1'b1;
        ambig_offset_next = in_r.hit_offset;
      end else if (in_r.hit_gene == 15'd0) begin
        // no gene, nothing to record
      end else if (in_r.hit_class == phcc_pkg::CLASS_EXACT && matched) begin
        exact_done_next   = 1'b1;
        exact_gene_next   = in_r.hit_gene;
        exact_offset_next = in_r.hit_offset;
      end else if (in_r.hit_class == phcc_pkg::CLASS_AMBIG) begin
        // unmarked class-2 hit is dropped
      end else if (mismatched) begin
        if (!mismatch_seen) begin
          mismatch_seen_next   = 1'b1;
          mismatch_offset_next = in_r.hit_offset;
        end
      end else if (!loose_seen) begin
        loose_seen_next   = 1'b1;
        loose_gene_next   = in_r.hit_gene;
        loose_sample_next = key;
        loose_class_next  = in_r.hit_class;
        loose_offset_next = in_r.hit_offset;
      end else if (loose_gene != in_r.hit_gene || loose_sample != key) begin
        conflict_seen_next   = 1'b1;
        conflict_offset_next = in_r.hit_offset;
      end
    end
  end

  // decision by priority over the updated state
  always_comb begin
    verdict_next = '0;
    if (exact_done_next) begin
      verdict_next.decision       = phcc_pkg::DEC_KEEP;
      verdict_next.gene_index     = exact_gene_next;
      verdict_next.ambiguous_code = ambig_seen_next;
      verdict_next.offset_out     = exact_offset_next;
    end else if (ambig_seen_next) begin
      verdict_next.decision       = phcc_pkg::DEC_DENY;
      verdict_next.ambiguous_code = 1'b1;
      verdict_next.offset_out     = ambig_offset_next;
    end else if (conflict_seen_next) begin
      verdict_next.decision       = phcc_pkg::DEC_DENY;
      verdict_next.ambiguous_code = 1'b1;
      verdict_next.offset_out     = conflict_offset_next;
    end else if (loose_seen_next) begin
      verdict_next.decision   = phcc_pkg::DEC_KEEP;
      verdict_next.gene_index = loose_gene_next;
      verdict_next.class_out  = loose_class_next;
      verdict_next.offset_out = loose_offset_next;
    end else if (mismatch_seen_next) begin
      verdict_next.decision       = phcc_pkg::DEC_DENY;
      verdict_next.ambiguous_code = 1'b1;
      verdict_next.offset_out     = mismatch_offset_next;
    end
  end

  // state flags, cleared at the end of each read
  always_ff @(posedge clk) begin
    if (rst || (adv && in_r.last_hit)) begin
      exact_done    <= 1'b0;
      ambig_seen    <= 1'b0;
      mismatch_seen <= 1'b0;
      loose_seen    <= 1'b0;
      conflict_seen <= 1'b0;
    end else begin
      exact_done    <= exact_done_next;
      ambig_seen    <= ambig_seen_next;
      mismatch_seen <= mismatch_seen_next;
      loose_seen    <= loose_seen_next;
      conflict_seen <= conflict_seen_next;
    end
  end

  // recorded fields, only read under their flags
  always_ff @(posedge clk) begin
    exact_gene      <= exact_gene_next;
    exact_offset    <= exact_offset_next;
    ambig_offset    <= ambig_offset_next;
    mismatch_offset <= mismatch_offset_next;
    loose_gene      <= loose_gene_next;
    loose_sample    <= loose_sample_next;
    loose_class     <= loose_class_next;
    loose_offset    <= loose_offset_next;
    conflict_offset <= conflict_offset_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else if (adv && in_r.last_hit) begin
      verdict_valid <= 1'b1;
    end else if (!verdict_stall) begin
      verdict_valid <= 1'b0;
    end
    if (adv && in_r.last_hit) begin
      verdict <= verdict_next;
    end
  end

endmodule
